@@ rtl/core/tdcrd_pkg.sv @@
// Shared types and constants for the TDC readout word decoder.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package tdcrd_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned TypeLsb    = 27;
  localparam int unsigned TypeW      = 5;
  localparam int unsigned ChannelW   = 7;
  localparam int unsigned ChannelLsb = 19;
  localparam int unsigned HitTimeW   = 19;
  localparam int unsigned HitIndexW  = 6;
  localparam int unsigned HitCountW  = 7;
  localparam int unsigned ErrorW     = 15;
  localparam int unsigned EventNumW  = 22;
  localparam int unsigned EventLsb   = 5;

  // Hit limit per event; the hit counter saturates here.
  localparam int unsigned MaxHits    = 64;
  localparam int unsigned HitCntW    = $clog2(MaxHits + 1);

  // Result payload: 77 bits of fields, padded to whole bytes.
  localparam int unsigned ResFieldsW = ChannelW + HitTimeW + HitIndexW + HitCountW
                                     + ErrorW + EventNumW + 1;
  localparam int unsigned ResDataW   = ((ResFieldsW + 7) / 8) * 8;

  typedef enum logic [TypeW-1:0] {
    TypeMeasure = 5'h00,
    TypeError   = 5'h04,
    TypeHeader  = 5'h08,
    TypeTrailer = 5'h10
  } word_type_e;

  typedef enum logic {
    KindHit = 1'b0,
    KindEnd = 1'b1
  } kind_e;

  typedef struct packed {
    logic                 overflow;
    logic [EventNumW-1:0] event_number;
    logic [ErrorW-1:0]    error_bits;
    logic [HitCountW-1:0] hit_count;
    logic [HitIndexW-1:0] hit_index;
    logic [HitTimeW-1:0]  hit_time;
    logic [ChannelW-1:0]  channel;
  } res_fields_t;

  typedef struct packed {
    kind_e       kind;
    res_fields_t fields;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/tdc_readout_word_decoder.sv @@
// Top level of the TDC readout word decoder: input stage, decode, result register.
// Depends on tdcrd_pkg, tdcrd_in_stage, tdcrd_decode, tdcrd_out_reg.
//
// Usage:
//   Readout words (32 bits) enter on the s_axis channel. Global headers latch
//   the event number, error words latch the error flags, measurement words
//   give a hit result and global trailers give an end-of-event summary, after
//   which hit count, error flags and overflow are cleared. Other words are
//   dropped. Hits beyond MaxHits per event are dropped and flagged.
//   Results leave on m_axis: tuser is the kind (0 hit, 1 end of event), tdata
//   carries the fields.
//   Throughput: one word per cycle while m_axis_tready stays high. A word
//   passes through the input register, then the result register, to reach
//   m_axis; decode is one pass of logic between them.
//   Stall: while m_axis_tready is low the result holds; the input register
//   takes one more word if empty, then s_axis_tready drops until the result moves.
//   Reset: asynchronous, active low; both stages empty, all event state zero.
`timescale 1ns / 1ps
`default_nettype none

module tdc_readout_word_decoder
  import tdcrd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [WordW-1:0]    s_axis_tdata,   // [31:0] word
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [6:0] channel, [25:7] hit_time, [31:26] hit_index, [38:32] hit_count,
  // [53:39] error_bits, [75:54] event_number, [76] overflow, [79:77] zero
  output logic [ResDataW-1:0]      m_axis_tdata,
  output logic                     m_axis_tuser    // [0] kind
);

  logic             in_valid;
  logic [WordW-1:0] in_word;
  logic             out_ready;
  logic             pop;
  logic             res_valid;
  result_t          res;
  result_t          res_out;

  assign pop = in_valid && out_ready;

  tdcrd_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .pop_i         (pop),
    .valid_o       (in_valid),
    .word_o        (in_word)
  );

  tdcrd_decode u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (pop),
    .word_i      (in_word),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tdcrd_out_reg u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (res_valid),
    .res_i     (res),
    .ready_o   (out_ready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .res_o     (res_out)
  );

  assign m_axis_tdata = ResDataW'(res_out.fields);
  assign m_axis_tuser = res_out.kind;

endmodule

`default_nettype wire

@@ rtl/core/tdcrd_in_stage.sv @@
// Input register stage: captures one readout word per cycle while empty or while the held word is consumed.
// Depends on tdcrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdcrd_in_stage
  import tdcrd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [WordW-1:0] s_axis_tdata,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WordW-1:0]      word_o
);

  logic             valid_q, valid_d;
  logic [WordW-1:0] word_q;

  // Refill in the same cycle the held word is consumed.
  assign s_axis_tready = !valid_q || pop_i;
  assign valid_d       = s_axis_tready ? s_axis_tvalid : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      word_q <= s_axis_tdata;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

@@ rtl/core/tdcrd_decode.sv @@
// Word type decode and per-event state (hit count, error, event number, overflow).
// Depends on tdcrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdcrd_decode
  import tdcrd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             take_i,
  input  wire logic [WordW-1:0] word_i,
  output logic                  res_valid_o,
  output result_t               res_o
);

  logic [HitCntW-1:0]   hits_q, hits_d;
  logic [ErrorW-1:0]    err_q, err_d;
  logic [EventNumW-1:0] evt_q, evt_d;
  logic                 ovf_q, ovf_d;
  logic [TypeW-1:0]     wtype;
  logic [31:0]          hits_ext;
  logic                 at_limit;

  assign wtype    = word_i[TypeLsb +: TypeW];
  assign hits_ext = 32'(hits_q);
  assign at_limit = (hits_q >= HitCntW'(MaxHits));

  always_comb begin
    hits_d      = hits_q;
    err_d       = err_q;
    evt_d       = evt_q;
    ovf_d       = ovf_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.kind  = KindHit;
    if (take_i) begin
      unique case (wtype)
        TypeHeader: begin
          evt_d = word_i[EventLsb +: EventNumW];
        end
        TypeError: begin
          err_d = word_i[ErrorW-1:0];
        end
        TypeMeasure: begin
          if (at_limit) begin
            ovf_d = 1'b1;
          end else begin
            res_valid_o            = 1'b1;
            res_o.fields.channel   = word_i[ChannelLsb +: ChannelW];
            res_o.fields.hit_time  = word_i[HitTimeW-1:0];
            res_o.fields.hit_index = hits_ext[HitIndexW-1:0];
            hits_d                 = hits_q + HitCntW'(1);
          end
        end
        TypeTrailer: begin
          res_valid_o               = 1'b1;
          res_o.kind                = KindEnd;
          res_o.fields.hit_count    = hits_ext[HitCountW-1:0];
          res_o.fields.error_bits   = err_q;
          res_o.fields.event_number = evt_q;
          res_o.fields.overflow     = ovf_q;
          hits_d                    = '0;
          err_d                     = '0;
          ovf_d                     = 1'b0;
        end
        default: begin
          // other word types carry nothing we keep
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q <= '0;
      err_q  <= '0;
      evt_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      hits_q <= hits_d;
      err_q  <= err_d;
      evt_q  <= evt_d;
      ovf_q  <= ovf_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tdcrd_out_reg.sv @@
// Result register toward the output stream.
// Depends on tdcrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdcrd_out_reg
  import tdcrd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     load_i,
  input  wire result_t  res_i,
  output logic          ready_o,
  output logic          m_valid_o,
  input  wire logic     m_ready_i,
  output result_t       res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign ready_o = !valid_q || m_ready_i;
  assign valid_d = ready_o ? load_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign res_o     = res_q;

endmodule

`default_nettype wire

@@ rtl/core/tdcrd_checker.sv @@
// Port-level checks for the TDC readout word decoder, bound to the top level.
// Depends on tdcrd_pkg and tdc_readout_word_decoder.
`timescale 1ns / 1ps
`default_nettype none

module tdcrd_checker
  import tdcrd_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [ResDataW-1:0] m_axis_tdata,
  input wire logic                m_axis_tuser
);

  localparam int unsigned HiFieldsLsb = ChannelW + HitTimeW + HitIndexW;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                       && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Hit results leave the event summary fields at zero.
  a_hit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KindHit)
      |-> (m_axis_tdata[ResDataW-1:HiFieldsLsb] == '0))
    else $error("hit result carries summary bits");

  // End-of-event results leave the hit fields at zero.
  a_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KindEnd)
      |-> (m_axis_tdata[HiFieldsLsb-1:0] == '0))
    else $error("end result carries hit bits");

  // A result appearing on an idle output came from an accepted input word, via the input and result registers.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without matching input word");

  // With the output empty the input side never stalls.
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output empty");

endmodule

bind tdc_readout_word_decoder tdcrd_checker u_tdcrd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking bench for tdc_readout_word_decoder: streams readout words, predicts
// hit and end-of-event words in a behavioral model and compares them on m_axis.
// Depends on tdcrd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module testbench;
  import tdcrd_pkg::*;

  localparam int unsigned RepW = ResDataW + 1;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [WordW-1:0]    s_axis_tdata = '0;   // [31:0] word
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [6:0] channel, [25:7] hit_time, [31:26] hit_index, [38:32] hit_count,
  // [53:39] error_bits, [75:54] event_number, [76] overflow, [79:77] zero
  logic [ResDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;        // [0] kind

  tdc_readout_word_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  // Idle percentages for the word source and the result sink.
  int unsigned src_idle_pct  = 38;
  int unsigned sink_idle_pct = 50;

  // Event state of the decoder model.
  int unsigned          hits_in_event;
  logic [ErrorW-1:0]    err_flags;
  logic [EventNumW-1:0] evt_num;
  logic                 hit_overflow;

  result_t     readout_results_q[$];
  int unsigned decoded_words;
  int unsigned mismatch_count;

  // Updates the event state for one accepted word and queues the word it yields.
  function automatic void decode_readout_word(input logic [WordW-1:0] w);
    result_t r;
    r = '0;
    case (w[TypeLsb +: TypeW])
      TypeHeader: begin
        evt_num = w[EventLsb +: EventNumW];
        decoded_words++;
      end
      TypeError: begin
        err_flags = w[ErrorW-1:0];
        decoded_words++;
      end
      TypeMeasure: begin
        decoded_words++;
        if (hits_in_event >= MaxHits) begin
          hit_overflow = 1'b1;
        end else begin
          r.kind             = KindHit;
          r.fields.channel   = w[ChannelLsb +: ChannelW];
          r.fields.hit_time  = w[HitTimeW-1:0];
          r.fields.hit_index = HitIndexW'(hits_in_event);
          hits_in_event++;
          readout_results_q.push_back(r);
        end
      end
      TypeTrailer: begin
        decoded_words++;
        r.kind                = KindEnd;
        r.fields.hit_count    = HitCountW'(hits_in_event);
        r.fields.error_bits   = err_flags;
        r.fields.event_number = evt_num;
        r.fields.overflow     = hit_overflow;
        readout_results_q.push_back(r);
        hits_in_event = 0;
        err_flags     = '0;
        hit_overflow  = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // valid is only lowered while idling, so back-to-back words keep it high
  task automatic send_word(input logic [WordW-1:0] w);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decode_readout_word(w);
  endtask

  function automatic logic [WordW-1:0] meas_word(input logic [ChannelW-1:0] ch,
                                                 input logic [HitTimeW-1:0] t,
                                                 input logic b26);
    return {TypeMeasure, b26, ch, t};
  endfunction

  function automatic logic [WordW-1:0] header_word(input logic [EventNumW-1:0] ev);
    return {TypeHeader, ev, 5'($urandom)};
  endfunction

  function automatic logic [WordW-1:0] error_word(input logic [ErrorW-1:0] e);
    return {TypeError, 12'($urandom), e};
  endfunction

  function automatic logic [WordW-1:0] trailer_word();
    return {TypeTrailer, 27'($urandom)};
  endfunction

  function automatic logic [WordW-1:0] other_word();
    logic [TypeW-1:0] t;
    do t = TypeW'($urandom); while (t == TypeMeasure || t == TypeError ||
                                     t == TypeHeader || t == TypeTrailer);
    return {t, 27'($urandom)};
  endfunction

  function automatic logic [WordW-1:0] random_hit();
    return meas_word(ChannelW'($urandom), HitTimeW'($urandom), 1'($urandom));
  endfunction

  task automatic report_mismatch(input string what, input logic [RepW-1:0] want,
                                 input logic [RepW-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t mismatch in %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
  endtask

  // sink stall pattern
  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind   = kind_e'(m_axis_tuser);
      got.fields = m_axis_tdata[ResFieldsW-1:0];
      if (readout_results_q.size() == 0) begin
        report_mismatch("unexpected word", '0, {m_axis_tuser, m_axis_tdata});
      end else begin
        want = readout_results_q.pop_front();
        if (got.kind != want.kind)
          report_mismatch("kind", RepW'(want.kind), RepW'(got.kind));
        if (got.fields.channel != want.fields.channel)
          report_mismatch("channel", RepW'(want.fields.channel),
                          RepW'(got.fields.channel));
        if (got.fields.hit_time != want.fields.hit_time)
          report_mismatch("hit_time", RepW'(want.fields.hit_time),
                          RepW'(got.fields.hit_time));
        if (got.fields.hit_index != want.fields.hit_index)
          report_mismatch("hit_index", RepW'(want.fields.hit_index),
                          RepW'(got.fields.hit_index));
        if (got.fields.hit_count != want.fields.hit_count)
          report_mismatch("hit_count", RepW'(want.fields.hit_count),
                          RepW'(got.fields.hit_count));
        if (got.fields.error_bits != want.fields.error_bits)
          report_mismatch("error_bits", RepW'(want.fields.error_bits),
                          RepW'(got.fields.error_bits));
        if (got.fields.event_number != want.fields.event_number)
          report_mismatch("event_number", RepW'(want.fields.event_number),
                          RepW'(got.fields.event_number));
        if (got.fields.overflow != want.fields.overflow)
          report_mismatch("overflow", RepW'(want.fields.overflow),
                          RepW'(got.fields.overflow));
      end
    end
  end

  // Field extremes, every word type, ignored types, error replacement and
  // the event number surviving a trailer.
  task automatic test_word_types();
    send_word({TypeHeader, 22'h3FFFFF, 5'h00});
    send_word({TypeError, 12'hFFF, 15'h7FFF});
    send_word(meas_word(7'h7F, 19'h7FFFF, 1'b1));
    send_word(meas_word(7'h00, 19'h00000, 1'b0));
    send_word(meas_word(7'h55, 19'h2AAAA, 1'b0));
    send_word({5'h01, 27'($urandom)});   // TDC header
    send_word({5'h03, 27'($urandom)});   // TDC trailer
    send_word({5'h11, 27'($urandom)});   // time tag
    send_word({5'h18, 27'($urandom)});   // filler
    send_word({5'h1F, 27'h7FFFFFF});
    send_word({5'h0C, 27'h0});
    send_word({TypeTrailer, 27'h7FFFFFF});
    send_word({TypeTrailer, 27'h0});     // empty event keeps the event number
    send_word({TypeHeader, 22'h0, 5'h1F});
    send_word(error_word(15'h5555));
    send_word(error_word(15'h2AAA));     // replaces the previous flags
    send_word(trailer_word());
    send_word(random_hit());
    send_word(trailer_word());
  endtask

  // Hits past the limit are dropped and flagged; the next trailer clears the flag.
  task automatic test_hit_limit();
    send_word(header_word(EventNumW'($urandom)));
    repeat (MaxHits + 3) send_word(random_hit());
    send_word(trailer_word());
    send_word(trailer_word());
  endtask

  // Mostly well-formed events with random content, some stray and broken words.
  task automatic test_random_stream(input int unsigned word_target);
    int unsigned start;
    int unsigned n_hits;
    start = decoded_words;
    while (decoded_words - start < word_target) begin
      if ($urandom_range(99) < 15) begin
        send_word($urandom());
      end else begin
        n_hits = ($urandom_range(15) == 0) ? $urandom_range(MaxHits + 4, MaxHits - 2)
                                          : $urandom_range(8);
        if ($urandom_range(9) != 0) send_word(header_word(EventNumW'($urandom)));
        if ($urandom_range(2) == 0) send_word(error_word(ErrorW'($urandom)));
        repeat (n_hits) begin
          case ($urandom_range(19))
            0:       send_word(other_word());
            1:       send_word(error_word(ErrorW'($urandom)));
            default: send_word(random_hit());
          endcase
        end
        if ($urandom_range(19) != 0) send_word(trailer_word());
      end
    end
  endtask

  initial begin
    int unsigned drain;
    hits_in_event = 0;
    err_flags     = '0;
    evt_num       = '0;
    hit_overflow  = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_word_types();
    test_hit_limit();
    test_random_stream(350);
    src_idle_pct  = 50;
    sink_idle_pct = 38;
    test_random_stream(350);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_stream(350);
    s_axis_tvalid <= 1'b0;

    drain = 0;
    while (readout_results_q.size() != 0 && drain < 20000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (10) @(posedge clk_i);
    mismatch_count += readout_results_q.size();
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
